>>> rtl/core/tuc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package tuc_pkg;

	localparam int DIV_W = 32;
	localparam logic [31:0] FREQ_RESET = 32'd10000000;
	localparam logic [31:0] MS_PER_S = 32'd1000;
	localparam logic [31:0] US_PER_S = 32'd1000000;
	localparam logic [31:0] MAC_MAX = 32'h7fffffff;
	// smallest microsecond count whose millisecond value exceeds the 31-bit maximum
	localparam logic [63:0] US_SAT = 64'd2147483648000;
	// ceil(2^30 / 1000), exact divide by 1000 for values below one million
	localparam logic [20:0] MS_RECIP = 21'd1073742;

	typedef struct packed {
		logic        act;
		logic        zero;
		logic        sat;
		logic [31:0] k;
	} ctx1_t;

	typedef struct packed {
		logic        act;
		logic        zero;
		logic        sat;
		logic [31:0] q;
		logic [63:0] qp;
	} ctx2_t;

	typedef struct packed {
		logic        act;
		logic        zero;
		logic        sat;
		logic [62:0] sum;
		logic [31:0] ms;
	} ctx3_t;

endpackage
`default_nettype wire

>>> rtl/core/timer_units_converter.sv
// throughput: one word per cycle while the output skid stage is empty (en high),
// set by two pipelined restoring dividers (one bit a stage)
// microseconds to milliseconds by a reciprocal multiply in a single stage
// a two-entry output register with skid stage holds results while the sink stalls
// reset (arst_n low, asynchronous) empties the pipeline and loads tick_frequency = 10000000
`timescale 1ns / 1ps
`default_nettype none
module timer_units_converter
	import tuc_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [31:0] cfg_data,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	// [31:0] mac_delay, [95:32] host_ticks_in
	input  wire logic [95:0] s_axis_tdata,
	// [0] action
	input  wire logic        s_axis_tuser,
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	// [62:0] host_ticks_out, [94:63] mac_delay_out, [95] zero
	output logic [95:0]      m_axis_tdata
);

	logic        en;
	logic [31:0] freq_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			freq_q <= FREQ_RESET;
		end else if (cfg_valid) begin
			freq_q <= cfg_data;
		end
	end

	assign s_axis_tready = en;

	// front end: pick dividend, divisor and scale per action
	logic [31:0] delay;
	logic [63:0] ticks;
	logic        pos;
	logic [31:0] mag;
	logic [31:0] divf;
	logic [31:0] hi_c, lo_c, d_c;
	ctx1_t       ctx1_c;

	always_comb begin
		delay = s_axis_tdata[31:0];
		ticks = s_axis_tdata[95:32];
		pos = (delay != 32'd0) && !delay[31];
		mag = pos ? delay : 32'd0 - delay;
		divf = (freq_q == 32'd0) ? 32'd1 : freq_q;
		ctx1_c.act = s_axis_tuser;
		if (!s_axis_tuser) begin
			hi_c = 32'd0;
			lo_c = mag;
			d_c = pos ? MS_PER_S : US_PER_S;
			ctx1_c.k = freq_q;
			ctx1_c.zero = 1'b0;
			ctx1_c.sat = 1'b0;
		end else begin
			hi_c = ticks[63:32];
			lo_c = ticks[31:0];
			d_c = divf;
			ctx1_c.k = US_PER_S;
			ctx1_c.zero = ticks[63];
			// quotient would not fit 32 bits
			ctx1_c.sat = ticks[63:32] >= divf;
		end
	end

	logic        v_s1;
	logic [31:0] hi_s1, lo_s1, d_s1;
	ctx1_t       ctx1_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			hi_s1 <= ctx1_c.sat ? 32'd0 : hi_c;
			lo_s1 <= lo_c;
			d_s1 <= d_c;
			ctx1_s1 <= ctx1_c;
		end
	end

	logic              v1;
	logic [31:0]       q1, r1, d1;
	logic [$bits(ctx1_t)-1:0] side1;
	ctx1_t             ctx1;

	tuc_div #(.W(DIV_W), .SW($bits(ctx1_t))) u_div1 (
		.clk(clk), .arst_n(arst_n), .en(en),
		.in_v(v_s1), .in_hi(hi_s1), .in_lo(lo_s1), .in_d(d_s1), .in_side(ctx1_s1),
		.out_v(v1), .out_q(q1), .out_r(r1), .out_d(d1), .out_side(side1)
	);

	assign ctx1 = side1;

	// scale quotient and remainder
	logic        v_s2;
	logic [63:0] m_s2;
	logic [31:0] d_s2;
	ctx2_t       ctx2_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s2 <= v1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			m_s2 <= {32'd0, r1} * {32'd0, ctx1.k};
			d_s2 <= d1;
			ctx2_s2.act <= ctx1.act;
			ctx2_s2.zero <= ctx1.zero;
			ctx2_s2.sat <= ctx1.sat;
			ctx2_s2.q <= q1;
			ctx2_s2.qp <= {32'd0, q1} * {32'd0, ctx1.k};
		end
	end

	logic        v2;
	logic [31:0] q2, r2_unused, d2_unused;
	logic [$bits(ctx2_t)-1:0] side2;
	ctx2_t       ctx2;

	tuc_div #(.W(DIV_W), .SW($bits(ctx2_t))) u_div2 (
		.clk(clk), .arst_n(arst_n), .en(en),
		.in_v(v_s2), .in_hi(m_s2[63:32]), .in_lo(m_s2[31:0]), .in_d(d_s2),
		.in_side(ctx2_s2),
		.out_v(v2), .out_q(q2), .out_r(r2_unused), .out_d(d2_unused), .out_side(side2)
	);

	assign ctx2 = side2;

	// microseconds (host ticks when action is 0), and milliseconds as q1 * 1000 + q2 / 1000
	logic        v_s3;
	logic [41:0] msq_c;
	logic [40:0] frac_c;
	ctx3_t       ctx3_c;
	ctx3_t       ctx3_s3;

	always_comb begin
		msq_c = {10'd0, ctx2.q} * 42'(MS_PER_S);
		// q2 stays below one million on the host to mac path
		frac_c = {21'd0, q2[19:0]} * {20'd0, MS_RECIP};
		ctx3_c.act = ctx2.act;
		ctx3_c.zero = ctx2.zero;
		ctx3_c.sat = ctx2.sat;
		ctx3_c.sum = ctx2.qp[62:0] + {31'd0, q2};
		ctx3_c.ms = msq_c[31:0] + {21'd0, frac_c[40:30]};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s3 <= v2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ctx3_s3 <= ctx3_c;
		end
	end

	logic [62:0] host_c;
	logic [31:0] mac_c;
	logic [95:0] res_c;

	always_comb begin
		host_c = ctx3_s3.act ? 63'd0 : ctx3_s3.sum;
		if (!ctx3_s3.act || ctx3_s3.zero) begin
			mac_c = 32'd0;
		end else if (ctx3_s3.sat || ({1'b0, ctx3_s3.sum} >= US_SAT)) begin
			mac_c = MAC_MAX;
		end else if (ctx3_s3.sum[62:31] == 32'd0) begin
			mac_c = 32'd0 - ctx3_s3.sum[31:0];
		end else begin
			mac_c = ctx3_s3.ms;
		end
		res_c = {1'b0, mac_c, host_c};
	end

	tuc_obuf #(.DW(96)) u_obuf (
		.clk(clk), .arst_n(arst_n),
		.in_v(v_s3 && en), .in_data(res_c), .en(en),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata)
	);

endmodule
`default_nettype wire

>>> rtl/core/tuc_div.sv
`timescale 1ns / 1ps
`default_nettype none
module tuc_div #(
	parameter int W = 32,
	parameter int SW = 1
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          en,
	input  wire logic          in_v,
	input  wire logic [W-1:0]  in_hi,
	input  wire logic [W-1:0]  in_lo,
	input  wire logic [W-1:0]  in_d,
	input  wire logic [SW-1:0] in_side,
	output logic               out_v,
	output logic [W-1:0]       out_q,
	output logic [W-1:0]       out_r,
	output logic [W-1:0]       out_d,
	output logic [SW-1:0]      out_side
);

	logic          v_s    [W];
	logic [W-1:0]  rem_s  [W];
	logic [W-1:0]  quo_s  [W];
	logic [W-1:0]  d_s    [W];
	logic [SW-1:0] side_s [W];

	for (genvar i = 0; i < W; i++) begin : g_stage
		logic          pv;
		logic [W-1:0]  prem;
		logic [W-1:0]  plo;
		logic [W-1:0]  pd;
		logic [SW-1:0] pside;
		logic [W:0]    t;
		logic          ge;
		logic [W:0]    diff;

		if (i == 0) begin : g_first
			assign pv = in_v;
			assign prem = in_hi;
			assign plo = in_lo;
			assign pd = in_d;
			assign pside = in_side;
		end else begin : g_next
			assign pv = v_s[i-1];
			assign prem = rem_s[i-1];
			assign plo = quo_s[i-1];
			assign pd = d_s[i-1];
			assign pside = side_s[i-1];
		end

		// one restoring step: shift in the next dividend bit, subtract if it fits
		assign t = {prem, plo[W-1]};
		assign ge = t >= {1'b0, pd};
		assign diff = t - {1'b0, pd};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[i] <= 1'b0;
			end else if (en) begin
				v_s[i] <= pv;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[i] <= ge ? diff[W-1:0] : t[W-1:0];
				quo_s[i] <= {plo[W-2:0], ge};
				d_s[i] <= pd;
				side_s[i] <= pside;
			end
		end
	end

	assign out_v = v_s[W-1];
	assign out_q = quo_s[W-1];
	assign out_r = rem_s[W-1];
	assign out_d = d_s[W-1];
	assign out_side = side_s[W-1];

endmodule
`default_nettype wire

>>> rtl/core/tuc_obuf.sv
`timescale 1ns / 1ps
`default_nettype none
module tuc_obuf #(
	parameter int DW = 8
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_v,
	input  wire logic [DW-1:0] in_data,
	output logic               en,
	output logic               m_axis_tvalid,
	input  wire logic          m_axis_tready,
	output logic [DW-1:0]      m_axis_tdata
);

	logic          out_v_q;
	logic          skid_v_q;
	logic [DW-1:0] out_d_q;
	logic [DW-1:0] skid_d_q;

	assign en = !skid_v_q;
	assign m_axis_tvalid = out_v_q;
	assign m_axis_tdata = out_d_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (skid_v_q) begin
			if (m_axis_tready) begin
				out_v_q <= 1'b1;
				skid_v_q <= 1'b0;
			end
		end else if (in_v) begin
			if (out_v_q && !m_axis_tready) begin
				skid_v_q <= 1'b1;
			end else begin
				out_v_q <= 1'b1;
			end
		end else if (m_axis_tready) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_v_q) begin
			if (m_axis_tready) begin
				out_d_q <= skid_d_q;
			end
		end else if (in_v) begin
			if (out_v_q && !m_axis_tready) begin
				skid_d_q <= in_data;
			end else begin
				out_d_q <= in_data;
			end
		end
	end

endmodule
`default_nettype wire
